@@ rtl/ppe_pkg.sv @@
`default_nettype none
package ppe_pkg;
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;
    localparam logic [1:0] OP_DRAW   = 2'd3;

    localparam logic [1:0] CFG_GRAV_X = 2'd0;
    localparam logic [1:0] CFG_GRAV_Y = 2'd1;
    localparam logic [1:0] CFG_GRAV_Z = 2'd2;
    localparam logic [1:0] CFG_LIMIT  = 2'd3;

    // One stored particle, all fields packed into one memory word.
    typedef struct packed {
        logic [23:0] px;
        logic [23:0] py;
        logic [23:0] pz;
        logic [15:0] vx;
        logic [15:0] vy;
        logic [15:0] vz;
        logic [15:0] life;
        logic [15:0] color;
    } particle_t;

    // Gravity values handed to the update unit.
    typedef struct packed {
        logic [15:0] gx;
        logic [15:0] gy;
        logic [15:0] gz;
    } gravity_t;
endpackage
`default_nettype wire

@@ rtl/ppe_update.sv @@
`default_nettype none
// Shared update unit: one particle per use, moved and aged.
module ppe_update
(
    input  wire ppe_pkg::particle_t cur,
    input  wire ppe_pkg::gravity_t  grav,
    output ppe_pkg::particle_t      nxt,
    output logic                    dead
);
    always_comb
    begin
        nxt      = cur;
        nxt.px   = cur.px + {{8{cur.vx[15]}}, cur.vx};
        nxt.py   = cur.py + {{8{cur.vy[15]}}, cur.vy};
        nxt.pz   = cur.pz + {{8{cur.vz[15]}}, cur.vz};
        nxt.vx   = cur.vx + grav.gx;
        nxt.vy   = cur.vy + grav.gy;
        nxt.vz   = cur.vz + grav.gz;
        if (!cur.life[15] && (cur.life != 16'd0))
            nxt.life = cur.life - 16'd1;
        dead = (nxt.life == 16'd0);
    end
endmodule
`default_nettype wire

@@ rtl/ppe_pixel.sv @@
`default_nettype none
// Screen mapping: position divided by 256 toward zero, then bounds check.
module ppe_pixel #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 128
)
(
    input  wire  [23:0] px,
    input  wire  [23:0] py,
    output logic [6:0]  col,
    output logic [6:0]  row,
    output logic        on
);
    logic [15:0] qx;
    logic [15:0] qy;
    always_comb
    begin
        // Negative values truncate toward zero, so a fraction rounds up.
        qx = px[23:8] + {15'd0, px[23] & (px[7:0] != 8'd0)};
        qy = py[23:8] + {15'd0, py[23] & (py[7:0] != 8'd0)};
        on = !qx[15] && !qy[15]
            && ({16'd0, qx} < 32'(SCREEN_WIDTH))
            && ({16'd0, qy} < 32'(SCREEN_HEIGHT));
        col = qx[6:0];
        row = qy[6:0];
    end
endmodule
`default_nettype wire

@@ rtl/particle_pool_engine_unit.sv @@
`default_nettype none
// Add returns its result word in the cycle after start is taken; remove passes through S_REM
// and then S_DONE, or goes straight to S_DONE when the slot is out of range.
// Tick alternates S_TICK and S_RD for each slot visit, and a slot is visited again when a dead particle
// is replaced by the last one; an empty pool goes straight to S_DONE.
// Draw gives one result word per cycle, one per stored particle (one for an empty pool).
// A new word is taken the cycle after the last result; the receiver cannot stall.
// Reset clears the count and the gravity and sets the limit to 32; particle memory is not cleared.
module particle_pool_engine_unit #(
    parameter int MAX_SLOTS     = 32,
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 128
)
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         start,
    output logic        busy,
    input  wire         cfg_we,
    input  wire  [1:0]  cfg_index,
    input  wire  [15:0] cfg_data,
    input  wire  [1:0]  operation,
    input  wire  [23:0] pos_x,
    input  wire  [23:0] pos_y,
    input  wire  [23:0] pos_z,
    input  wire  [15:0] vel_x,
    input  wire  [15:0] vel_y,
    input  wire  [15:0] vel_z,
    input  wire  [15:0] life_ticks,
    input  wire  [15:0] color,
    input  wire  [4:0]  slot_index,
    input  wire         use_override,
    output logic        result_valid,
    output logic [6:0]  pixel_x,
    output logic [6:0]  pixel_y,
    output logic [15:0] pixel_color,
    output logic        point_valid,
    output logic        accepted,
    output logic [5:0]  particle_count,
    output logic        last
);
    localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;  // memory read issued, data next cycle
    localparam logic [2:0] S_TICK  = 3'd2;  // update one slot
    localparam logic [2:0] S_DRAW  = 3'd3;  // emit one draw word per cycle
    localparam logic [2:0] S_REM   = 3'd4;  // copy last particle into a slot
    localparam logic [2:0] S_DONE  = 3'd5;

    // The particle memory: one write port, one registered read port.
    ppe_pkg::particle_t mem [MAX_SLOTS];
    ppe_pkg::particle_t rd_q;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    ppe_pkg::particle_t wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_q <= mem[rd_addr];
    end

    logic [2:0]          state_reg, state_next;
    logic [5:0]          count_reg, count_next;
    logic [5:0]          idx_reg, idx_next;
    logic [5:0]          slot_reg, slot_next;
    logic                acc_reg, acc_next;
    logic                ovr_reg;
    logic [15:0]         ocol_reg;
    ppe_pkg::gravity_t   grav_reg;
    logic [5:0]          limit_reg;
    logic                pend_reg, pend_next; // tick: swapped-in slot still to move

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grav_reg  <= '0;
            limit_reg <= 6'd32;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ppe_pkg::CFG_GRAV_X: grav_reg.gx <= cfg_data;
                ppe_pkg::CFG_GRAV_Y: grav_reg.gy <= cfg_data;
                ppe_pkg::CFG_GRAV_Z: grav_reg.gz <= cfg_data;
                ppe_pkg::CFG_LIMIT:  limit_reg   <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    ppe_pkg::particle_t upd;
    logic               upd_dead;
    ppe_update u_upd (.cur(rd_q), .grav(grav_reg), .nxt(upd), .dead(upd_dead));

    logic [6:0] pcol, prow;
    logic       pon;
    ppe_pixel #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_pix
    (
        .px(rd_q.px), .py(rd_q.py), .col(pcol), .row(prow), .on(pon)
    );

    logic op_add_ok;
    assign op_add_ok = (count_reg < limit_reg) && ({26'd0, count_reg} < 32'(MAX_SLOTS));

    // Sequencer: one memory read and at most one write per cycle drive the whole operation.
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        slot_next  = slot_reg;
        acc_next   = acc_reg;
        pend_next  = pend_reg;
        rd_addr    = idx_reg[AW-1:0];
        wr_en      = 1'b0;
        wr_addr    = idx_reg[AW-1:0];
        wr_data    = upd;
        result_valid   = 1'b0;
        pixel_x        = 7'd0;
        pixel_y        = 7'd0;
        pixel_color    = 16'd0;
        point_valid    = 1'b0;
        accepted       = 1'b0;
        particle_count = count_reg;
        last           = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    acc_next = 1'b0;
                    idx_next = 6'd0;
                    unique case (operation)
                        ppe_pkg::OP_ADD:
                        begin
                            wr_addr = count_reg[AW-1:0];
                            wr_data = '{pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                                        life_ticks, color};
                            if (op_add_ok)
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + 6'd1;
                                acc_next   = 1'b1;
                            end
                            state_next = S_DONE;
                        end
                        ppe_pkg::OP_REMOVE:
                        begin
                            if ({1'b0, slot_index} < count_reg)
                            begin
                                acc_next   = 1'b1;
                                slot_next  = {1'b0, slot_index};
                                idx_next   = count_reg - 6'd1;
                                rd_addr    = count_reg[AW-1:0] - AW'(1);
                                state_next = S_REM;
                            end
                            else
                                state_next = S_DONE;
                        end
                        ppe_pkg::OP_TICK:
                        begin
                            rd_addr    = '0;
                            state_next = (count_reg == 6'd0) ? S_DONE : S_TICK;
                        end
                        ppe_pkg::OP_DRAW:
                        begin
                            rd_addr    = '0;
                            state_next = S_DRAW;
                        end
                        default: ;
                    endcase
                end
            end
            S_REM:
            begin
                // rd_q holds the last particle; write it over the freed slot.
                wr_en      = (slot_reg != idx_reg);
                wr_addr    = slot_reg[AW-1:0];
                wr_data    = rd_q;
                count_next = count_reg - 6'd1;
                state_next = S_DONE;
            end
            S_TICK:
            begin
                if (!upd_dead)
                begin
                    wr_en    = 1'b1;
                    idx_next = idx_reg + 6'd1;
                    if (idx_reg + 6'd1 < count_reg)
                    begin
                        rd_addr    = idx_reg[AW-1:0] + AW'(1);
                        state_next = S_RD;
                    end
                    else
                        state_next = S_DONE;
                end
                else
                begin
                    count_next = count_reg - 6'd1;
                    if (idx_reg + 6'd1 < count_reg)
                    begin
                        // Fetch the last particle; it lands in this slot next.
                        rd_addr    = count_reg[AW-1:0] - AW'(1);
                        pend_next  = 1'b1;
                        state_next = S_RD;
                    end
                    else
                        state_next = S_DONE;
                end
            end
            S_RD:
            begin
                // Re-issue the read for the next update. After a death the count has
                // already dropped, so the count itself addresses the last particle,
                // which is updated and then written over the dead slot.
                rd_addr    = pend_reg ? count_reg[AW-1:0] : idx_reg[AW-1:0];
                pend_next  = 1'b0;
                state_next = S_TICK;
            end
            S_DRAW:
            begin
                result_valid = 1'b1;
                if (count_reg == 6'd0)
                begin
                    last       = 1'b1;
                    particle_count = 6'd0;
                    state_next = S_IDLE;
                end
                else
                begin
                    point_valid = pon;
                    pixel_x     = pon ? pcol : 7'd0;
                    pixel_y     = pon ? prow : 7'd0;
                    pixel_color = pon ? (ovr_reg ? ocol_reg : rd_q.color) : 16'd0;
                    rd_addr     = idx_reg[AW-1:0] + AW'(1);
                    idx_next    = idx_reg + 6'd1;
                    if (idx_reg + 6'd1 >= count_reg)
                    begin
                        last       = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_DONE:
            begin
                result_valid = 1'b1;
                accepted     = acc_reg;
                last         = 1'b1;
                state_next   = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= 6'd0;
            idx_reg      <= 6'd0;
            slot_reg     <= 6'd0;
            acc_reg      <= 1'b0;
            pend_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            slot_reg     <= slot_next;
            acc_reg      <= acc_next;
            pend_reg     <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            ovr_reg  <= use_override;
            ocol_reg <= color;
        end
    end

    assign busy = (state_reg != S_IDLE);

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        {26'd0, count_reg} <= 32'(MAX_SLOTS))
        else $error("particle count above pool size");
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> (result_valid && last))
        else $error("single result missing last");
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> !result_valid)
        else $error("result while idle");
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("start not taken");
`endif
endmodule
`default_nettype wire

@@ tb/sv/particle_pool_engine_unit_test.sv @@
`timescale 1ns / 1ps
module particle_pool_engine_unit_test;
    localparam int SLOTS      = 32;
    localparam int SCR_W      = 128;
    localparam int SCR_H      = 128;
    localparam int CYCLE_CAP  = 600000;
    localparam int DRAIN_WAIT = 100;

    // One input word as the sender presents it.
    typedef struct {
        logic [1:0]  op;
        logic [23:0] px;
        logic [23:0] py;
        logic [23:0] pz;
        logic [15:0] vx;
        logic [15:0] vy;
        logic [15:0] vz;
        logic [15:0] life;
        logic [15:0] color;
        logic [4:0]  slot;
        logic        ovr;
    } cmd_word_t;

    // One result word as the block reports it.
    typedef struct {
        logic [6:0]  pix_x;
        logic [6:0]  pix_y;
        logic [15:0] pix_color;
        logic        on_screen;
        logic        took;
        logic [5:0]  count;
        logic        fin;
    } result_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = ppe_pkg::CFG_GRAV_X;
    logic [15:0] cfg_data = '0;
    logic [1:0]  operation = ppe_pkg::OP_ADD;
    logic [23:0] pos_x = '0;
    logic [23:0] pos_y = '0;
    logic [23:0] pos_z = '0;
    logic [15:0] vel_x = '0;
    logic [15:0] vel_y = '0;
    logic [15:0] vel_z = '0;
    logic [15:0] life_ticks = '0;
    logic [15:0] color = '0;
    logic [4:0]  slot_index = '0;
    logic        use_override = 1'b0;
    wire         busy;
    wire         result_valid;
    wire  [6:0]  pixel_x;
    wire  [6:0]  pixel_y;
    wire  [15:0] pixel_color;
    wire         point_valid;
    wire         accepted;
    wire  [5:0]  particle_count;
    wire         last;

    particle_pool_engine_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .operation(operation), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z), .life_ticks(life_ticks),
        .color(color), .slot_index(slot_index), .use_override(use_override),
        .result_valid(result_valid), .pixel_x(pixel_x), .pixel_y(pixel_y),
        .pixel_color(pixel_color), .point_valid(point_valid), .accepted(accepted),
        .particle_count(particle_count), .last(last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Words waiting to be sent, and result words the pool model has produced.
    cmd_word_t    pending_cmds[$];
    result_word_t expected_results[$];
    int           error_count = 0;
    int           cycle_count = 0;
    bit           no_idle = 1'b0;

    // Mirror of the pool and its registers, updated as words are accepted.
    logic [23:0] pool_px[SLOTS];
    logic [23:0] pool_py[SLOTS];
    logic [23:0] pool_pz[SLOTS];
    logic [15:0] pool_vx[SLOTS];
    logic [15:0] pool_vy[SLOTS];
    logic [15:0] pool_vz[SLOTS];
    logic [15:0] pool_life[SLOTS];
    logic [15:0] pool_color[SLOTS];
    logic [5:0]  pool_count = '0;
    logic [15:0] grav_x = '0;
    logic [15:0] grav_y = '0;
    logic [15:0] grav_z = '0;
    logic [5:0]  pool_limit = 6'd32;

    // Swap-with-last removal; returns whether the slot was live.
    function automatic bit pool_remove(int idx);
        if (idx >= pool_count)
            return 1'b0;
        if (idx + 1 < pool_count)
        begin
            pool_px[idx]    = pool_px[pool_count - 1];
            pool_py[idx]    = pool_py[pool_count - 1];
            pool_pz[idx]    = pool_pz[pool_count - 1];
            pool_vx[idx]    = pool_vx[pool_count - 1];
            pool_vy[idx]    = pool_vy[pool_count - 1];
            pool_vz[idx]    = pool_vz[pool_count - 1];
            pool_life[idx]  = pool_life[pool_count - 1];
            pool_color[idx] = pool_color[pool_count - 1];
        end
        pool_count = pool_count - 1'b1;
        return 1'b1;
    endfunction

    // Applies one accepted word to the mirror and queues the result words it causes.
    function automatic void predict_pool(cmd_word_t w);
        result_word_t r;
        int           i;
        int           cx;
        int           cy;
        bit           took;
        took = 1'b0;
        r = '{default: '0};
        if (w.op == ppe_pkg::OP_DRAW)
        begin
            if (pool_count == 0)
            begin
                r.fin = 1'b1;
                expected_results.push_back(r);
                return;
            end
            for (i = 0; i < pool_count; i++)
            begin
                // Signed division in SystemVerilog truncates toward zero, as the pixel does.
                cx = $signed(pool_px[i]) / 256;
                cy = $signed(pool_py[i]) / 256;
                r = '{default: '0};
                if (cx >= 0 && cx < SCR_W && cy >= 0 && cy < SCR_H)
                begin
                    r.pix_x     = cx[6:0];
                    r.pix_y     = cy[6:0];
                    r.pix_color = w.ovr ? w.color : pool_color[i];
                    r.on_screen = 1'b1;
                end
                r.count = pool_count;
                r.fin   = (i + 1 == pool_count);
                expected_results.push_back(r);
            end
            return;
        end
        if (w.op == ppe_pkg::OP_ADD)
        begin
            if (pool_count < pool_limit && pool_count < SLOTS)
            begin
                pool_px[pool_count]    = w.px;
                pool_py[pool_count]    = w.py;
                pool_pz[pool_count]    = w.pz;
                pool_vx[pool_count]    = w.vx;
                pool_vy[pool_count]    = w.vy;
                pool_vz[pool_count]    = w.vz;
                pool_life[pool_count]  = w.life;
                pool_color[pool_count] = w.color;
                pool_count = pool_count + 1'b1;
                took = 1'b1;
            end
        end
        else if (w.op == ppe_pkg::OP_REMOVE)
        begin
            took = pool_remove(w.slot);
        end
        else
        begin
            // A particle swapped into a freed slot is moved before the walk goes on.
            i = 0;
            while (i < pool_count)
            begin
                pool_px[i] = pool_px[i] + {{8{pool_vx[i][15]}}, pool_vx[i]};
                pool_py[i] = pool_py[i] + {{8{pool_vy[i][15]}}, pool_vy[i]};
                pool_pz[i] = pool_pz[i] + {{8{pool_vz[i][15]}}, pool_vz[i]};
                pool_vx[i] = pool_vx[i] + grav_x;
                pool_vy[i] = pool_vy[i] + grav_y;
                pool_vz[i] = pool_vz[i] + grav_z;
                if ($signed(pool_life[i]) > 0)
                    pool_life[i] = pool_life[i] - 1'b1;
                if (pool_life[i] == 16'd0)
                    void'(pool_remove(i));
                else
                    i++;
            end
        end
        r.took  = took;
        r.count = pool_count;
        r.fin   = 1'b1;
        expected_results.push_back(r);
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Driver: presents the next pending word and holds start until the block takes it.
    int        gap_left = 0;
    cmd_word_t cur_cmd;
    always @(posedge clk)
    begin
        bit drive_start;
        if (rst_n)
        begin
            drive_start = start;
            if (start && !busy)
            begin
                predict_pool(cur_cmd);
                drive_start = 1'b0;
                gap_left = pick_gap();
            end
            if (!drive_start)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_cmds.size() > 0)
                begin
                    cur_cmd = pending_cmds.pop_front();
                    operation    <= cur_cmd.op;
                    pos_x        <= cur_cmd.px;
                    pos_y        <= cur_cmd.py;
                    pos_z        <= cur_cmd.pz;
                    vel_x        <= cur_cmd.vx;
                    vel_y        <= cur_cmd.vy;
                    vel_z        <= cur_cmd.vz;
                    life_ticks   <= cur_cmd.life;
                    color        <= cur_cmd.color;
                    slot_index   <= cur_cmd.slot;
                    use_override <= cur_cmd.ovr;
                    drive_start = 1'b1;
                end
            end
            start <= drive_start;
        end
    end

    function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            error_count++;
        end
    endfunction

    // Monitor: every strobed result word is matched against the oldest prediction.
    always @(posedge clk)
    begin
        result_word_t exp_r;
        if (rst_n && result_valid)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result word, expected none, actual count %0d",
                         $time, particle_count);
                error_count++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                check_field("pixel_x", exp_r.pix_x, pixel_x);
                check_field("pixel_y", exp_r.pix_y, pixel_y);
                check_field("pixel_color", exp_r.pix_color, pixel_color);
                check_field("point_valid", exp_r.on_screen, point_valid);
                check_field("accepted", exp_r.took, accepted);
                check_field("particle_count", exp_r.count, particle_count);
                check_field("last", exp_r.fin, last);
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("timeout at %0t", $time);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Positions favor the screen area so draws produce real points.
    function automatic logic [23:0] rand_pos();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 6)
            return 24'($urandom_range(0, SCR_W * 256 + 1024)) - 24'd512;
        if (roll < 8)
            return 24'($urandom);
        return roll == 8 ? 24'h7fffff : 24'h800000;
    endfunction

    function automatic logic [15:0] rand_vel();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 7)
            return 16'($urandom_range(0, 1024)) - 16'd512;
        if (roll < 9)
            return 16'($urandom);
        return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
    endfunction

    function automatic logic [15:0] rand_life();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 6)
            return 16'($urandom_range(1, 8));
        if (roll == 6)
            return 16'd0;
        if (roll == 7)
            return 16'($urandom) | 16'h8000;
        return 16'($urandom);
    endfunction

    // Every field carries random content, even where the operation ignores it.
    function automatic cmd_word_t make_cmd(logic [1:0] op);
        cmd_word_t w;
        w.op    = op;
        w.px    = rand_pos();
        w.py    = rand_pos();
        w.pz    = 24'($urandom);
        w.vx    = rand_vel();
        w.vy    = rand_vel();
        w.vz    = rand_vel();
        w.life  = rand_life();
        w.color = 16'($urandom);
        w.slot  = 5'($urandom);
        w.ovr   = 1'($urandom);
        if (op == ppe_pkg::OP_ADD && $urandom_range(0, 3) == 0)
        begin
            // A flat add.
            w.pz = '0;
            w.vz = '0;
        end
        return w;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            ppe_pkg::CFG_GRAV_X: grav_x = val;
            ppe_pkg::CFG_GRAV_Y: grav_y = val;
            ppe_pkg::CFG_GRAV_Z: grav_z = val;
            default:             pool_limit = val[5:0];
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Waits until every sent word is answered, then lets the block settle.
    task automatic drain();
        @(posedge clk);
        while (pending_cmds.size() > 0 || start || expected_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic random_phase(int count);
        int roll;
        int k;
        logic [1:0] op;
        for (k = 0; k < count; k++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 40)
                op = ppe_pkg::OP_ADD;
            else if (roll < 58)
                op = ppe_pkg::OP_REMOVE;
            else if (roll < 80)
                op = ppe_pkg::OP_TICK;
            else
                op = ppe_pkg::OP_DRAW;
            pending_cmds.push_back(make_cmd(op));
        end
    endtask

    initial
    begin
        cmd_word_t w;
        int        k;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed words at reset settings: empty draw, a remove and a tick on an empty pool, extremes.
        pending_cmds.push_back(make_cmd(ppe_pkg::OP_DRAW));
        w = make_cmd(ppe_pkg::OP_REMOVE);
        w.slot = 5'd0;
        pending_cmds.push_back(w);
        pending_cmds.push_back(make_cmd(ppe_pkg::OP_TICK));
        w = make_cmd(ppe_pkg::OP_ADD);
        w.px = 24'h7fffff; w.py = 24'h800000; w.vx = 16'h7fff; w.vy = 16'h8000;
        w.life = 16'h7fff; w.color = 16'hffff;
        pending_cmds.push_back(w);
        w = make_cmd(ppe_pkg::OP_ADD);
        w.px = 24'h00ff00; w.py = 24'h007f80; w.vx = 16'd1; w.vy = 16'hffff;
        w.life = 16'd0; w.color = 16'h0000;
        pending_cmds.push_back(w);
        w = make_cmd(ppe_pkg::OP_ADD);
        w.px = 24'hffff01; w.py = 24'h000000; w.life = 16'h8000;
        pending_cmds.push_back(w);
        w = make_cmd(ppe_pkg::OP_ADD);
        w.px = 24'h003000; w.py = 24'h002000; w.life = 16'd1; w.pz = '0; w.vz = '0;
        pending_cmds.push_back(w);
        w = make_cmd(ppe_pkg::OP_DRAW);
        w.ovr = 1'b0;
        pending_cmds.push_back(w);
        w = make_cmd(ppe_pkg::OP_DRAW);
        w.ovr = 1'b1; w.color = 16'h5a5a;
        pending_cmds.push_back(w);
        // The zero-life add and the life-one add both leave on this tick.
        pending_cmds.push_back(make_cmd(ppe_pkg::OP_TICK));
        pending_cmds.push_back(make_cmd(ppe_pkg::OP_DRAW));
        w = make_cmd(ppe_pkg::OP_REMOVE);
        w.slot = 5'd31;
        pending_cmds.push_back(w);
        w = make_cmd(ppe_pkg::OP_REMOVE);
        w.slot = 5'd0;
        pending_cmds.push_back(w);
        pending_cmds.push_back(make_cmd(ppe_pkg::OP_DRAW));
        drain();

        // A tight limit, then a full pool.
        write_reg(ppe_pkg::CFG_LIMIT, 16'd2);
        for (k = 0; k < 4; k++)
            pending_cmds.push_back(make_cmd(ppe_pkg::OP_ADD));
        drain();
        write_reg(ppe_pkg::CFG_LIMIT, 16'd0);
        pending_cmds.push_back(make_cmd(ppe_pkg::OP_ADD));
        drain();
        write_reg(ppe_pkg::CFG_LIMIT, 16'd63);
        no_idle = 1'b1;
        for (k = 0; k < 34; k++)
        begin
            w = make_cmd(ppe_pkg::OP_ADD);
            w.life = 16'd50;
            pending_cmds.push_back(w);
        end
        pending_cmds.push_back(make_cmd(ppe_pkg::OP_DRAW));
        pending_cmds.push_back(make_cmd(ppe_pkg::OP_TICK));
        drain();
        no_idle = 1'b0;

        // Random phases across gravity and limit settings.
        write_reg(ppe_pkg::CFG_GRAV_X, 16'h7fff);
        write_reg(ppe_pkg::CFG_GRAV_Y, 16'h8000);
        write_reg(ppe_pkg::CFG_GRAV_Z, 16'h7fff);
        write_reg(ppe_pkg::CFG_LIMIT, 16'd32);
        random_phase(50);
        drain();
        write_reg(ppe_pkg::CFG_GRAV_X, 16'hfff0);
        write_reg(ppe_pkg::CFG_GRAV_Y, 16'h0010);
        write_reg(ppe_pkg::CFG_GRAV_Z, 16'h8000);
        write_reg(ppe_pkg::CFG_LIMIT, 16'd6);
        random_phase(50);
        drain();
        write_reg(ppe_pkg::CFG_GRAV_X, 16'h0000);
        write_reg(ppe_pkg::CFG_GRAV_Y, 16'h0000);
        write_reg(ppe_pkg::CFG_GRAV_Z, 16'h0000);
        write_reg(ppe_pkg::CFG_LIMIT, 16'd40);
        no_idle = 1'b1;
        random_phase(50);
        drain();
        no_idle = 1'b0;
        write_reg(ppe_pkg::CFG_LIMIT, 16'd1);
        random_phase(30);
        drain();
        for (k = 0; k < 3; k++)
        begin
            write_reg(ppe_pkg::CFG_GRAV_X, 16'($urandom_range(0, 64)) - 16'd32);
            write_reg(ppe_pkg::CFG_GRAV_Y, 16'($urandom));
            write_reg(ppe_pkg::CFG_GRAV_Z, 16'($urandom));
            write_reg(ppe_pkg::CFG_LIMIT, 16'($urandom_range(0, 63)));
            random_phase(25);
            drain();
        end

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

@@ sim.f @@
rtl/ppe_pkg.sv
rtl/ppe_update.sv
rtl/ppe_pixel.sv
rtl/particle_pool_engine_unit.sv
tb/sv/particle_pool_engine_unit_test.sv
